### design/omb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omb_pkg
// Shared types and codes for the oven mode and button sequencer.
// ----------------------------------------------------------------------------
package omb_pkg;

  localparam int unsigned TEMP_W  = 10;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned SEC_W   = 10;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_STEP_PRESSES = 60;
  localparam int unsigned CNT_W = $clog2(MAX_STEP_PRESSES + 1);
  // Signed press residue: 2*diff - step, then minus 2*step per press
  localparam int unsigned RES_W = TEMP_W + 3;

  localparam logic [TEMP_W-1:0] DEFAULT_SETPOINT_RST = TEMP_W'(350);
  localparam logic [STEP_W-1:0] STEP_SIZE_RST        = STEP_W'(5);
  localparam logic [SEC_W-1:0]  PREHEAT_DONE_RST     = SEC_W'(30);
  localparam logic [SEC_W-1:0]  SHUTOFF_RST          = SEC_W'(600);
  localparam logic [SEC_W-1:0]  SEC_MAX              = {SEC_W{1'b1}};

  // Operations
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_ON   = 2'd2;
  localparam logic [1:0] OP_OFF  = 2'd3;

  // Buttons
  localparam logic [2:0] BTN_NONE   = 3'd0;
  localparam logic [2:0] BTN_CANCEL = 3'd1;
  localparam logic [2:0] BTN_BAKE   = 3'd2;
  localparam logic [2:0] BTN_INC    = 3'd3;
  localparam logic [2:0] BTN_DEC    = 3'd4;
  localparam logic [2:0] BTN_START  = 3'd5;

  // Oven modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_BEGIN   = 2'd1;
  localparam logic [1:0] MODE_PREHEAT = 2'd2;
  localparam logic [1:0] MODE_ON      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SETPOINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT_DONE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTOFF          = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic              coil_on;
    logic [TEMP_W-1:0] setpoint_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] button;
    logic [1:0] oven_state;
    logic       state_changed;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       take;   // apply the accepted item
    logic       emit;   // load the output register
    logic [2:0] btn;
    logic       last;
    logic       step;   // advance the step press residue
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       is_tick;
    logic       tick_cancel;
    logic       tick_bake;
    logic       bake_q;
    logic       step_go;
    logic [2:0] step_btn;
    logic       slot_free;
  } status_t;

endpackage : omb_pkg
`default_nettype wire

### design/omb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omb_ctrl
// Press sequencer: walks cancel, bake, step presses, start, or a quiet press, for one tick.
// ----------------------------------------------------------------------------
module omb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire omb_pkg::status_t status_i,
  output omb_pkg::cmd_t        cmd_o
);
  import omb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CANCEL = 3'd1;
  localparam logic [2:0] S_BAKE   = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_START  = 3'd4;
  localparam logic [2:0] S_NONE   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.is_tick) begin
            if (status_i.tick_cancel)    state_d = S_CANCEL;
            else if (status_i.tick_bake) state_d = S_BAKE;
            else                         state_d = S_NONE;
          end
        end
      end
      S_CANCEL: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.btn  = BTN_CANCEL;
          cmd_o.last = !status_i.bake_q;
          state_d    = status_i.bake_q ? S_BAKE : S_IDLE;
        end
      end
      S_BAKE: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.btn  = BTN_BAKE;
          state_d    = S_STEP;
        end
      end
      S_STEP: begin
        if (!status_i.step_go) begin
          state_d = S_START;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.btn  = status_i.step_btn;
          cmd_o.step = 1'b1;
        end
      end
      S_START: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.btn  = BTN_START;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_NONE: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.btn  = BTN_NONE;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : omb_ctrl
`default_nettype wire

### design/omb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omb_dp
// Oven state, configuration, tick evaluation, press residue and output register.
// ----------------------------------------------------------------------------
module omb_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [omb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [omb_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire omb_pkg::in_item_t                  in_item_i,
  output omb_pkg::out_item_t                      out_item_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  input  wire omb_pkg::cmd_t                      cmd_i,
  output omb_pkg::status_t                        status_o
);
  import omb_pkg::*;

  // Configuration
  logic [TEMP_W-1:0] dflt_q;
  logic [STEP_W-1:0] step_q;
  logic [SEC_W-1:0]  pre_done_q;
  logic [SEC_W-1:0]  shutoff_q;

  // Oven state
  logic [1:0]        mode_q, mode_d;
  logic [TEMP_W-1:0] target_q, target_d;
  logic [TEMP_W-1:0] applied_q, applied_d;
  logic [SEC_W-1:0]  off_sec_q, off_sec_d;
  logic              started_q, started_d;
  logic              on_pend_q, off_pend_q;
  logic              changed_q, changed_d;
  logic              bake_q;
  logic              dec_q, dec_d;

  // Press residue and count
  logic signed [RES_W-1:0] res_q, res_d;
  logic [CNT_W-1:0]        cnt_q;
  logic [TEMP_W-1:0]       diff;

  // Output register
  out_item_t out_q;
  logic      out_valid_q;

  // Intermediate tick values
  logic [SEC_W-1:0]  off_time;
  logic [1:0]        mode_mv;
  logic              chg_mv;
  logic [TEMP_W-1:0] tgt_mv, app_mv;
  logic              set_req, cancel, bake;
  logic [1:0]        mode_cx;
  logic              is_tick;

  assign is_tick = in_item_i.operation == OP_TICK;

  always_comb begin
    // Off-time tracking
    started_d = started_q;
    off_sec_d = off_sec_q;
    if (in_item_i.coil_on) begin
      started_d = 1'b0;
      off_sec_d = '0;
    end else if (!started_q) begin
      started_d = 1'b1;
      off_sec_d = '0;
    end else if (off_sec_q != SEC_MAX) begin
      off_sec_d = off_sec_q + SEC_W'(1);
    end
    off_time = in_item_i.coil_on ? '0 : off_sec_d;

    // Mode moves
    mode_mv = mode_q;
    chg_mv  = 1'b0;
    tgt_mv  = target_q;
    app_mv  = applied_q;
    unique case (mode_q)
      MODE_OFF: begin
        if (in_item_i.coil_on) begin
          tgt_mv  = dflt_q;
          app_mv  = dflt_q;
          mode_mv = MODE_PREHEAT;
          chg_mv  = 1'b1;
        end
      end
      MODE_BEGIN: begin
        if (in_item_i.coil_on) begin
          mode_mv = MODE_PREHEAT;
          chg_mv  = 1'b1;
        end
      end
      MODE_PREHEAT: begin
        if (off_time > pre_done_q) begin
          mode_mv = MODE_ON;
          chg_mv  = 1'b1;
        end
      end
      default: begin
        if (off_time > shutoff_q) begin
          mode_mv = MODE_OFF;
          chg_mv  = 1'b1;
        end
      end
    endcase

    // Reapply a changed setpoint
    applied_d = app_mv;
    target_d  = tgt_mv;
    set_req   = 1'b0;
    if (tgt_mv != app_mv) begin
      applied_d = tgt_mv;
      set_req   = mode_mv != MODE_OFF;
    end

    cancel    = off_pend_q | set_req;
    mode_cx   = cancel ? MODE_OFF : mode_mv;
    bake      = (on_pend_q | set_req) && (mode_cx == MODE_OFF);
    mode_d    = bake ? MODE_BEGIN : mode_cx;
    changed_d = chg_mv | cancel | bake;

    // Step presses count from the default setpoint
    dec_d = !(applied_d > dflt_q);
    diff  = dec_d ? (dflt_q - applied_d) : (applied_d - dflt_q);
    res_d = $signed({2'b00, diff, 1'b0}) - $signed({{(RES_W-STEP_W){1'b0}}, step_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q     <= DEFAULT_SETPOINT_RST;
      step_q     <= STEP_SIZE_RST;
      pre_done_q <= PREHEAT_DONE_RST;
      shutoff_q  <= SHUTOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEFAULT_SETPOINT: dflt_q     <= cfg_data_i[TEMP_W-1:0];
        CFG_STEP_SIZE:        step_q     <= cfg_data_i[STEP_W-1:0];
        CFG_PREHEAT_DONE:     pre_done_q <= cfg_data_i[SEC_W-1:0];
        CFG_SHUTOFF:          shutoff_q  <= cfg_data_i[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OFF;
      target_q   <= '0;
      applied_q  <= '0;
      off_sec_q  <= '0;
      started_q  <= 1'b0;
      on_pend_q  <= 1'b0;
      off_pend_q <= 1'b0;
      changed_q  <= 1'b0;
      bake_q     <= 1'b0;
    end else if (cmd_i.take) begin
      case (in_item_i.operation)
        OP_SET: target_q   <= in_item_i.setpoint_value;
        OP_ON:  on_pend_q  <= 1'b1;
        OP_OFF: off_pend_q <= 1'b1;
        default: begin
          mode_q     <= mode_d;
          target_q   <= target_d;
          applied_q  <= applied_d;
          off_sec_q  <= off_sec_d;
          started_q  <= started_d;
          on_pend_q  <= 1'b0;
          off_pend_q <= 1'b0;
          changed_q  <= changed_d;
          bake_q     <= bake;
        end
      endcase
    end
  end

  // Residue: one press per positive residue, minus two steps per press
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      res_q <= res_d;
      cnt_q <= '0;
      dec_q <= dec_d;
    end else if (cmd_i.step) begin
      res_q <= res_q - $signed({{(RES_W-STEP_W-1){1'b0}}, step_q, 1'b0});
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.button        <= cmd_i.btn;
      out_q.oven_state    <= mode_q;
      out_q.state_changed <= cmd_i.last & changed_q;
      out_q.last          <= cmd_i.last;
    end
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign status_o.is_tick     = is_tick;
  assign status_o.tick_cancel = cancel;
  assign status_o.tick_bake   = bake;
  assign status_o.bake_q      = bake_q;
  assign status_o.step_go     = (res_q > $signed(RES_W'(0)))
                                && (cnt_q < CNT_W'(MAX_STEP_PRESSES));
  assign status_o.step_btn    = dec_q ? BTN_DEC : BTN_INC;
  assign status_o.slot_free   = !out_valid_q || out_ready_i;

endmodule : omb_dp
`default_nettype wire

### design/oven_mode_and_button_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oven_mode_and_button_sequencer
// Tracks oven mode from coil ticks and sends button presses for requests.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  in        in_valid_i / in_ready_o / in_item_i   operation, coil, setpoint
//  out       out_valid_o / out_ready_i / out_item_o one press per item
//  cfg       cfg_we_i / cfg_index_i / cfg_data_i   register write, no wait
//
//  Setpoint, on and off items are applied when taken and leave the sequencer
//  idle. A tick is evaluated in the cycle it is taken, then sends one press
//  per cycle while the output register has room: cancel, then bake, up to 60
//  step presses and start, either part alone, or one quiet press when nothing
//  is asked. The step state passes to start without a press once the step
//  presses are done. Each press waits while the output register is full.
//  Input is taken only while the sequencer is idle; the output register lets
//  the next item in while the last press still waits. No clearing after reset.
// ----------------------------------------------------------------------------
module oven_mode_and_button_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire omb_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output omb_pkg::out_item_t                  out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [omb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [omb_pkg::CFG_W-1:0]      cfg_data_i
);
  import omb_pkg::*;

  cmd_t    cmd;
  status_t status;

  omb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  omb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  a_changed_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.state_changed |-> out_item_o.last)
    else $error("state_changed set on a press that is not the last");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.button == BTN_NONE) |-> out_item_o.last)
    else $error("quiet result not marked last");

  a_start_begins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.button == BTN_START)
      |-> (out_item_o.oven_state == MODE_BEGIN) && out_item_o.last
        && out_item_o.state_changed)
    else $error("start press without begin preheat");

  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.operation == OP_TICK) |=> !in_ready_o)
    else $error("input taken while a tick is still being served");
`endif

endmodule : oven_mode_and_button_sequencer
`default_nettype wire

### tb/omb_press_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omb_press_checker
// Watches the item, press and register ports of the oven sequencer. Keeps its
// own copy of mode, setpoints, coil-off time and latched requests, predicts
// the presses of every accepted item and compares each press in order.
// ----------------------------------------------------------------------------
module omb_press_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  omb_pkg::in_item_t             in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  omb_pkg::out_item_t            out_item_i,
  input  logic                          cfg_we_i,
  input  logic [omb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [omb_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            failures_o,
  output int                            pending_o
);
  import omb_pkg::*;

  localparam int PRINT_CAP = 50;

  logic [TEMP_W-1:0] dflt_setpoint;
  logic [STEP_W-1:0] step_size;
  logic [SEC_W-1:0]  preheat_secs;
  logic [SEC_W-1:0]  shutoff_secs;

  logic [1:0]        oven_mode;
  logic [TEMP_W-1:0] target_temp;
  logic [TEMP_W-1:0] applied_temp;
  logic [SEC_W-1:0]  coil_off_secs;
  logic              off_timing;
  logic              on_req;
  logic              off_req;

  out_item_t expected_presses[$];
  int        failures = 0;

  task automatic report_mismatch(string what);
    failures++;
    if (failures <= PRINT_CAP) $display("%0t ns: press mismatch: %s", $time, what);
  endtask

  // Step presses to get within half a step of the wanted setpoint
  function automatic int step_presses(logic [TEMP_W-1:0] diff);
    int twice;
    int n;
    if (diff == '0) return 0;
    if (step_size == '0) return int'(MAX_STEP_PRESSES);
    twice = 2 * int'(diff);
    if (twice <= int'(step_size)) return 0;
    n = (twice + int'(step_size) - 1) / (2 * int'(step_size));
    if (n > int'(MAX_STEP_PRESSES)) n = int'(MAX_STEP_PRESSES);
    return n;
  endfunction

  task automatic predict_item(in_item_t it);
    logic [2:0]        presses[$];
    logic              changed;
    logic [SEC_W-1:0]  off_time;
    logic [TEMP_W-1:0] diff;
    logic [2:0]        step_btn;
    int                n;
    out_item_t         e;
    changed = 1'b0;
    case (it.operation)
      OP_SET: target_temp = it.setpoint_value;
      OP_ON:  on_req = 1'b1;
      OP_OFF: off_req = 1'b1;
      default: begin
        if (it.coil_on) begin
          off_timing    = 1'b0;
          coil_off_secs = '0;
        end else if (!off_timing) begin
          off_timing    = 1'b1;
          coil_off_secs = '0;
        end else if (coil_off_secs != SEC_MAX) begin
          coil_off_secs = coil_off_secs + 1'b1;
        end
        off_time = it.coil_on ? '0 : coil_off_secs;

        case (oven_mode)
          MODE_OFF: begin
            if (it.coil_on) begin
              target_temp  = dflt_setpoint;
              applied_temp = dflt_setpoint;
              oven_mode    = MODE_PREHEAT;
              changed      = 1'b1;
            end
          end
          MODE_BEGIN: begin
            if (it.coil_on) begin
              oven_mode = MODE_PREHEAT;
              changed   = 1'b1;
            end
          end
          MODE_PREHEAT: begin
            if (off_time > preheat_secs) begin
              oven_mode = MODE_ON;
              changed   = 1'b1;
            end
          end
          default: begin
            if (off_time > shutoff_secs) begin
              oven_mode = MODE_OFF;
              changed   = 1'b1;
            end
          end
        endcase

        // Reapply a changed setpoint by cycling the oven off and on
        if (target_temp != applied_temp) begin
          applied_temp = target_temp;
          if (oven_mode != MODE_OFF) begin
            off_req = 1'b1;
            on_req  = 1'b1;
          end
        end

        if (off_req) begin
          presses.push_back(BTN_CANCEL);
          off_req   = 1'b0;
          oven_mode = MODE_OFF;
          changed   = 1'b1;
        end

        // Serve an on request while the oven is off; drop it while the oven is running
        if (on_req) begin
          on_req = 1'b0;
          if (oven_mode == MODE_OFF) begin
            presses.push_back(BTN_BAKE);
            if (applied_temp > dflt_setpoint) begin
              diff     = applied_temp - dflt_setpoint;
              step_btn = BTN_INC;
            end else begin
              diff     = dflt_setpoint - applied_temp;
              step_btn = BTN_DEC;
            end
            n = step_presses(diff);
            repeat (n) presses.push_back(step_btn);
            presses.push_back(BTN_START);
            oven_mode = MODE_BEGIN;
            changed   = 1'b1;
          end
        end

        if (presses.size() == 0) presses.push_back(BTN_NONE);

        foreach (presses[k]) begin
          e.button        = presses[k];
          e.oven_state    = oven_mode;
          e.last          = (k == presses.size() - 1);
          e.state_changed = e.last & changed;
          expected_presses.push_back(e);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      dflt_setpoint = DEFAULT_SETPOINT_RST;
      step_size     = STEP_SIZE_RST;
      preheat_secs  = PREHEAT_DONE_RST;
      shutoff_secs  = SHUTOFF_RST;
      oven_mode     = MODE_OFF;
      target_temp   = '0;
      applied_temp  = '0;
      coil_off_secs = '0;
      off_timing    = 1'b0;
      on_req        = 1'b0;
      off_req       = 1'b0;
      expected_presses.delete();
      pending_o  <= 0;
      failures_o <= failures;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEFAULT_SETPOINT: dflt_setpoint = cfg_data_i[TEMP_W-1:0];
          CFG_STEP_SIZE:        step_size     = cfg_data_i[STEP_W-1:0];
          CFG_PREHEAT_DONE:     preheat_secs  = cfg_data_i[SEC_W-1:0];
          default:              shutoff_secs  = cfg_data_i[SEC_W-1:0];
        endcase
      end

      // Retire the press first: it can never stem from an item taken this edge
      if (out_valid_i && out_ready_i) begin
        if (expected_presses.size() == 0) begin
          report_mismatch($sformatf("button %0d with nothing expected", out_item_i.button));
        end else begin
          want = expected_presses.pop_front();
          if (out_item_i.button !== want.button)
            report_mismatch($sformatf("button %0d, want %0d",
                                      out_item_i.button, want.button));
          if (out_item_i.oven_state !== want.oven_state)
            report_mismatch($sformatf("oven_state %0d, want %0d",
                                      out_item_i.oven_state, want.oven_state));
          if (out_item_i.state_changed !== want.state_changed)
            report_mismatch($sformatf("state_changed %0b, want %0b",
                                      out_item_i.state_changed, want.state_changed));
          if (out_item_i.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_item_i.last, want.last));
        end
      end

      if (in_valid_i && in_ready_i) predict_item(in_item_i);

      pending_o  <= expected_presses.size();
      failures_o <= failures;
    end
  end

endmodule

### tb/tb_oven_mode_and_button_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oven_mode_and_button_sequencer
// Drives directed and random ticks, setpoints and on/off requests into the
// sequencer under several register settings, with random gaps on both
// channels, and lets the press checker judge every press.
// ----------------------------------------------------------------------------
module tb_oven_mode_and_button_sequencer;
  import omb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 70;
  localparam int PHASE_ITEMS   = 10;
  localparam int RANDOM_PHASES = 5;
  localparam int HOLD_TICKS    = 4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEFAULT_SETPOINT;
  logic [CFG_W-1:0]   cfg_data = '0;

  int                 failures;
  int                 pending;
  int                 cycle_count = 0;
  int                 items_sent = 0;
  bit                 steady = 1'b0;
  logic [TEMP_W-1:0]  cur_default = DEFAULT_SETPOINT_RST;
  logic [STEP_W-1:0]  cur_step = STEP_SIZE_RST;

  always #2 clk = ~clk;

  oven_mode_and_button_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  omb_press_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  // Mostly short gaps, a few long ones, none while steady
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Half full range, half close to the default so step counts stay short
  function automatic logic [TEMP_W-1:0] pick_setpoint();
    int span;
    int t;
    if ($urandom_range(0, 1)) return TEMP_W'($urandom_range(0, 1023));
    span = 3 * int'(cur_step) + 1;
    t = int'(cur_default) + int'($urandom_range(0, 2 * span)) - span;
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return TEMP_W'(t);
  endfunction

  task automatic send_item(logic [1:0] op, logic coil, logic [TEMP_W-1:0] sp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{op, coil, sp};
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain all presses, then give the sequencer time to finish any item
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [TEMP_W-1:0] ds, logic [CFG_W-1:0] ss,
                            logic [SEC_W-1:0] pd, logic [SEC_W-1:0] so);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEFAULT_SETPOINT;
    cfg_data  <= ds;
    @(posedge clk);
    cfg_index <= CFG_STEP_SIZE;
    cfg_data  <= ss;
    @(posedge clk);
    cfg_index <= CFG_PREHEAT_DONE;
    cfg_data  <= pd;
    @(posedge clk);
    cfg_index <= CFG_SHUTOFF;
    cfg_data  <= so;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_default = ds;
    cur_step    = ss[STEP_W-1:0];
  endtask

  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [TEMP_W-1:0] ds;
    logic [STEP_W-1:0] ss;
    logic [SEC_W-1:0]  pd;
    logic [SEC_W-1:0]  so;
    int                phase_end;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: quiet tick, power-on presses, setpoint reapply cases
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_ON, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '1);
    send_item(OP_TICK, 1'b1, '0);
    send_item(OP_SET, 1'b0, 10'd1023);
    send_item(OP_TICK, 1'b1, '0);
    send_item(OP_SET, 1'b1, 10'd352);
    send_item(OP_TICK, 1'b1, '0);
    send_item(OP_SET, 1'b0, 10'd353);
    send_item(OP_TICK, 1'b1, '1);
    send_item(OP_OFF, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b1, '0);
    // on request while running is dropped
    send_item(OP_ON, 1'b1, '1);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_OFF, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    // off while already off still counts as a mode change
    send_item(OP_OFF, 1'b1, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_SET, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_ON, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    settle();

    // All registers at zero: immediate preheat end, shutoff, zero step size
    set_config('0, '0, '0, '0);
    send_item(OP_TICK, 1'b1, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_SET, 1'b0, 10'd1023);
    send_item(OP_ON, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_SET, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          ds = '1; ss = '1; pd = '1; so = '1;
        end
        1: begin
          ds = '0; ss = 6'd1; pd = '0; so = '0;
        end
        default: begin
          ds = TEMP_W'($urandom_range(0, 1023));
          ss = ($urandom_range(0, 3) == 0) ? '0 : STEP_W'($urandom_range(1, 63));
          pd = SEC_W'($urandom_range(0, 4));
          so = SEC_W'($urandom_range(0, 8));
        end
      endcase
      // Upper data bits above the step size field must be dropped
      set_config(ds, {4'($urandom), ss}, pd, so);
      steady = (p == 2);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            // power up on the coil, then let it cool through the thresholds
            send_item(OP_TICK, 1'b1, TEMP_W'($urandom));
            repeat ($urandom_range(1, 8)) send_item(OP_TICK, 1'b0, TEMP_W'($urandom));
          end
          3, 4: begin
            send_item(OP_SET, 1'($urandom), pick_setpoint());
            send_item(OP_ON, 1'($urandom), TEMP_W'($urandom));
            send_item(OP_TICK, 1'($urandom), TEMP_W'($urandom));
          end
          5: begin
            send_item(OP_SET, 1'($urandom), pick_setpoint());
            send_item(OP_TICK, 1'($urandom), TEMP_W'($urandom));
          end
          6: begin
            send_item(OP_OFF, 1'($urandom), TEMP_W'($urandom));
            send_item(OP_TICK, 1'($urandom), TEMP_W'($urandom));
          end
          default: begin
            repeat ($urandom_range(1, 3))
              send_item(2'($urandom), 1'($urandom), TEMP_W'($urandom));
          end
        endcase
      end
      settle();
    end

    // Keep the oven on with the coil off under the largest shutoff times
    steady = 1'b0;
    ds = TEMP_W'($urandom_range(0, 1023));
    ss = STEP_W'($urandom_range(1, 63));
    set_config(ds, {4'b0, ss}, '0, SEC_MAX);
    send_item(OP_OFF, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b1, '0);
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_TICK, 1'b0, '0);
    steady = 1'b1;
    repeat (HOLD_TICKS) send_item(OP_TICK, 1'b0, TEMP_W'($urandom));
    settle();
    set_config(ds, {4'b0, ss}, '0, SEC_MAX - 1'b1);
    send_item(OP_TICK, 1'b0, '0);
    steady = 1'b0;
    settle();

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
